/* rtl/core/bidal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidal_pkg
// Shared types, sizes and helpers of the bidirectional ID alias table.
// ----------------------------------------------------------------------------
package bidal_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 64;
  localparam int PCNT_W = 6;

  typedef enum logic [2:0] {
    CMD_BIND     = 3'd0,
    CMD_CANON    = 3'd1,
    CMD_CANON_OB = 3'd2,
    CMD_FIND_LOC = 3'd3,
    CMD_FORGET_L = 3'd4,
    CMD_FORGET_C = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO     = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } ctrl_t;

  typedef struct packed {
    logic skip;
  } dp_stat_t;

  function automatic logic [PCNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+PCNT_W-1:0] wide;
    wide = (CNT_W + PCNT_W)'(c);
    if (wide > (CNT_W + PCNT_W)'((1 << PCNT_W) - 1)) begin
      return {PCNT_W{1'b1}};
    end
    return wide[PCNT_W-1:0];
  endfunction

endpackage

/* rtl/core/bidal_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidal_ctrl
// Command sequencer: walks the table one entry a cycle, then commits; clear and unused codes skip the walk.
// ----------------------------------------------------------------------------
module bidal_ctrl import bidal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctrl_t    ctrl,
  output logic     busy
);

  state_t           state, state_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    ctrl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load   = 1'b1;
          rd_idx_next = '0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.skip) begin
          state_next = S_COMMIT;
        end else begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_addr = rd_idx;
          if (rd_idx == IDX_W'(DEPTH - 1)) begin
            state_next = S_DRAIN;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/core/bidal_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidal_dp
// Pair storage, key compare stage, match capture and commit logic.
// ----------------------------------------------------------------------------
module bidal_dp import bidal_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  input  logic [2:0]        command,
  input  logic [ID_W-1:0]   canonical_id,
  input  logic [ID_W-1:0]   local_id,
  output dp_stat_t          stat,
  output logic              done,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   result_id,
  output logic [PCNT_W-1:0] pair_count
);

  logic [ID_W-1:0]  mem_local [DEPTH];
  logic [ID_W-1:0]  mem_canon [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [CNT_W-1:0] count;

  cmd_t             cmd_q;
  logic [ID_W-1:0]  key_local, key_canon, bind_canon;

  logic [ID_W-1:0]  loc_q, can_q;
  logic             vld_q, cmp_vld;
  logic [IDX_W-1:0] cmp_addr;

  logic             ls_hit, cs_hit, free_found;
  logic [IDX_W-1:0] ls_idx, cs_idx, free_idx;
  logic [ID_W-1:0]  ls_canon, cs_local;

  status_t          st_c;
  logic [ID_W-1:0]  res_c;
  logic [CNT_W-1:0] cnt_c;
  logic             wr_new, drop, clr;
  logic [IDX_W-1:0] drop_idx;

  assign stat.skip = (cmd_q == CMD_CLEAR) || (cmd_q != CMD_BIND && cmd_q != CMD_CANON &&
                      cmd_q != CMD_CANON_OB && cmd_q != CMD_FIND_LOC &&
                      cmd_q != CMD_FORGET_L && cmd_q != CMD_FORGET_C);

  // table memories
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      loc_q <= mem_local[ctrl.rd_addr];
      can_q <= mem_canon[ctrl.rd_addr];
    end
    if (ctrl.commit && wr_new) begin
      mem_local[free_idx] <= key_local;
      mem_canon[free_idx] <= bind_canon;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      count   <= '0;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      done    <= ctrl.commit;
      cmp_vld <= ctrl.rd_en;
      if (ctrl.commit) begin
        count <= cnt_c;
        if (clr) begin
          valid <= '0;
        end else if (wr_new) begin
          valid[free_idx] <= 1'b1;
        end else if (drop) begin
          valid[drop_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q      <= cmd_t'(command);
      key_local  <= local_id;
      bind_canon <= canonical_id;
      key_canon  <= (cmd_t'(command) == CMD_CANON_OB) ? local_id : canonical_id;
      ls_hit     <= 1'b0;
      cs_hit     <= 1'b0;
      free_found <= 1'b0;
    end
    if (ctrl.rd_en) begin
      vld_q    <= valid[ctrl.rd_addr];
      cmp_addr <= ctrl.rd_addr;
    end
    if (cmp_vld) begin
      if (vld_q && loc_q == key_local && !ls_hit) begin
        ls_hit   <= 1'b1;
        ls_idx   <= cmp_addr;
        ls_canon <= can_q;
      end
      if (vld_q && can_q == key_canon && !cs_hit) begin
        cs_hit   <= 1'b1;
        cs_idx   <= cmp_addr;
        cs_local <= loc_q;
      end
      if (!vld_q && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_addr;
      end
    end
    if (ctrl.commit) begin
      status     <= st_c;
      result_id  <= res_c;
      pair_count <= sat_count(cnt_c);
    end
  end

  always_comb begin
    st_c     = ST_DONE;
    res_c    = '0;
    cnt_c    = count;
    wr_new   = 1'b0;
    drop     = 1'b0;
    clr      = 1'b0;
    drop_idx = ls_idx;
    unique case (cmd_q)
      CMD_BIND: begin
        if (bind_canon == '0 || key_local == '0) begin
          st_c = ST_ZERO;
        end else if ((ls_hit && ls_canon != bind_canon) ||
                     (cs_hit && cs_local != key_local)) begin
          st_c = ST_CONFLICT;
        end else if (bind_canon == key_local || ls_hit) begin
          st_c = ST_DONE;
        end else if (count >= CNT_W'(DEPTH) || !free_found) begin
          st_c = ST_FULL;
        end else begin
          wr_new = 1'b1;
          cnt_c  = count + 1'b1;
        end
      end
      CMD_CANON: begin
        res_c = ls_hit ? ls_canon : key_local;
      end
      CMD_CANON_OB: begin
        if (ls_hit) begin
          res_c = ls_canon;
        end else if (cs_hit && cs_local != key_local) begin
          res_c = '0;
        end else begin
          res_c = key_local;
        end
      end
      CMD_FIND_LOC: begin
        res_c = cs_hit ? cs_local : '0;
      end
      CMD_FORGET_L: begin
        if (ls_hit) begin
          drop  = 1'b1;
          cnt_c = count - 1'b1;
        end
      end
      CMD_FORGET_C: begin
        drop_idx = cs_idx;
        if (cs_hit) begin
          drop  = 1'b1;
          cnt_c = count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        clr   = 1'b1;
        cnt_c = '0;
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

endmodule

/* rtl/core/bidirectional_id_alias_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidirectional_id_alias_table_top
// Bounded table of local/canonical 64-bit ID pairs, searchable both ways.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low;
//   command, canonical_id and local_id are sampled on that edge.
//   Every command answers with one result beat: done is high for exactly
//   one cycle with status, result_id and pair_count valid in that cycle.
//   The receiver cannot stall; the result must be taken when done is high.
//   Table commands walk all 32 entries through one read port of the pair
//   memory, one entry per cycle, then pass the drain and commit states
//   before done rises. Clear and the unused command code skip the walk
//   and go straight from the scan state to the commit state.
//   busy drops in the cycle done is shown, so a new command can be issued
//   there; no new command is taken while one is still in work.
//   Reset empties the table (all entries invalid, count zero); the block
//   is ready right after reset.
// ----------------------------------------------------------------------------
module bidirectional_id_alias_table_top import bidal_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command,
  input  logic [ID_W-1:0]   canonical_id,
  input  logic [ID_W-1:0]   local_id,
  output logic              done,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   result_id,
  output logic [PCNT_W-1:0] pair_count
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  bidal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  bidal_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (command),
    .canonical_id (canonical_id),
    .local_id     (local_id),
    .stat         (stat),
    .done         (done),
    .status       (status),
    .result_id    (result_id),
    .pair_count   (pair_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bidirectional ID alias table against an in-bench pair table
// model. A short scripted sequence covers reset state, zero IDs, conflicts in
// both directions, equal IDs, rebinding, the observation zero answer, forgets,
// clear and the unused command code. Random episodes then fill, drain and mix
// the table with random start gaps, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import bidal_pkg::*;

  localparam logic [2:0]      CMD_UNUSED    = 3'd7;
  localparam int              POOL_SIZE     = 128;
  localparam int              RANDOM_BEATS  = 750;
  localparam int              STALL_LIMIT   = 2000;
  localparam int              SETTLE_CYCLES = 40;
  localparam logic [ID_W-1:0] L1 = 64'h0000_0000_0000_0001;
  localparam logic [ID_W-1:0] C1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ID_W-1:0] L2 = 64'h8000_0000_0000_0000;
  localparam logic [ID_W-1:0] C2 = 64'h7FFF_FFFF_FFFF_FFFE;
  localparam logic [ID_W-1:0] L3 = 64'hA5A5_5A5A_0F0F_F0F0;
  localparam logic [ID_W-1:0] C3 = 64'h5A5A_A5A5_F0F0_0F0F;

  typedef struct {
    logic [1:0]        status;
    logic [ID_W-1:0]   id;
    logic [PCNT_W-1:0] count;
  } answer_t;

  typedef struct {
    logic [2:0]      cmd;
    logic [ID_W-1:0] can_id;
    logic [ID_W-1:0] loc_id;
    bit              typed;
    answer_t         want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        command = CMD_BIND;
  logic [ID_W-1:0]   canonical_id = '0;
  logic [ID_W-1:0]   local_id = '0;
  logic              done;
  logic [1:0]        status;
  logic [ID_W-1:0]   result_id;
  logic [PCNT_W-1:0] pair_count;

  bit              pair_used [DEPTH];
  logic [ID_W-1:0] pair_loc [DEPTH];
  logic [ID_W-1:0] pair_can [DEPTH];
  int              pairs_held = 0;

  logic [ID_W-1:0] id_pool [POOL_SIZE];
  answer_t         pending_answers [$];
  script_row_t     script [$];
  int              mismatches = 0;
  int              stall_cycles = 0;

  bidirectional_id_alias_table_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .canonical_id (canonical_id),
    .local_id     (local_id),
    .done         (done),
    .status       (status),
    .result_id    (result_id),
    .pair_count   (pair_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int slot_of_local(logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (pair_used[i] && pair_loc[i] == id) return i;
    return -1;
  endfunction

  function automatic int slot_of_canonical(logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (pair_used[i] && pair_can[i] == id) return i;
    return -1;
  endfunction

  // Applies one command to the pair table and returns the answer it gives.
  function automatic answer_t alias_table_answer(logic [2:0] cmd, logic [ID_W-1:0] can,
                                                 logic [ID_W-1:0] loc);
    answer_t a;
    int      ls;
    int      cs;
    int      free_slot;
    a.status = ST_DONE;
    a.id = '0;
    case (cmd)
      CMD_BIND: begin
        ls = slot_of_local(loc);
        cs = slot_of_canonical(can);
        if (can == '0 || loc == '0) begin
          a.status = ST_ZERO;
        end else if ((ls >= 0 && pair_can[ls] != can) || (cs >= 0 && pair_loc[cs] != loc)) begin
          a.status = ST_CONFLICT;
        end else if (can != loc && ls < 0) begin
          if (pairs_held >= DEPTH) begin
            a.status = ST_FULL;
          end else begin
            free_slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--)
              if (!pair_used[i]) free_slot = i;
            pair_used[free_slot] = 1'b1;
            pair_loc[free_slot] = loc;
            pair_can[free_slot] = can;
            pairs_held++;
          end
        end
      end
      CMD_CANON: begin
        ls = slot_of_local(loc);
        a.id = (ls >= 0) ? pair_can[ls] : loc;
      end
      CMD_CANON_OB: begin
        ls = slot_of_local(loc);
        if (ls >= 0) begin
          a.id = pair_can[ls];
        end else begin
          cs = slot_of_canonical(loc);
          a.id = (cs >= 0 && pair_loc[cs] != loc) ? '0 : loc;
        end
      end
      CMD_FIND_LOC: begin
        cs = slot_of_canonical(can);
        a.id = (cs >= 0) ? pair_loc[cs] : '0;
      end
      CMD_FORGET_L: begin
        ls = slot_of_local(loc);
        if (ls >= 0) begin
          pair_used[ls] = 1'b0;
          pairs_held--;
        end
      end
      CMD_FORGET_C: begin
        cs = slot_of_canonical(can);
        if (cs >= 0) begin
          pair_used[cs] = 1'b0;
          pairs_held--;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) pair_used[i] = 1'b0;
        pairs_held = 0;
      end
      default: ;
    endcase
    a.count = (pairs_held > 63) ? '1 : PCNT_W'(pairs_held);
    return a;
  endfunction

  // Key biased toward stored pairs; sometimes the opposite side of a pair.
  function automatic logic [ID_W-1:0] pick_key(bit want_local);
    int              r;
    int              s;
    logic [ID_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 55 && pairs_held > 0) begin
      s = $urandom_range(0, DEPTH - 1);
      while (!pair_used[s]) s = (s + 1) % DEPTH;
      if (want_local ^ ($urandom_range(0, 99) < 15)) k = pair_loc[s];
      else k = pair_can[s];
    end else if (r < 80) begin
      k = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (r < 88) begin
      k = {$urandom, $urandom};
    end else if (r < 94) begin
      k = '0;
    end else begin
      case ($urandom_range(0, 2))
        0: k = L1;
        1: k = C1;
        default: k = L2;
      endcase
    end
    return k;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 150);
  endfunction

  task automatic add_row(logic [2:0] cmd, logic [ID_W-1:0] can, logic [ID_W-1:0] loc,
                         bit typed, logic [1:0] st, logic [ID_W-1:0] id,
                         logic [PCNT_W-1:0] cnt);
    script_row_t row;
    row.cmd = cmd;
    row.can_id = can;
    row.loc_id = loc;
    row.typed = typed;
    row.want.status = st;
    row.want.id = id;
    row.want.count = cnt;
    script.push_back(row);
  endtask

  task automatic issue_beat(logic [2:0] cmd, logic [ID_W-1:0] can, logic [ID_W-1:0] loc,
                            bit typed, answer_t typed_ans, int gap);
    answer_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    canonical_id <= can;
    local_id <= loc;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = alias_table_answer(cmd, can, loc);
    pending_answers.push_back(typed ? typed_ans : pred);
  endtask

  task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat with none pending", result_id, '0);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status)
          report_mismatch("status", ID_W'(status), ID_W'(want.status));
        if (result_id !== want.id) report_mismatch("result_id", result_id, want.id);
        if (pair_count !== want.count)
          report_mismatch("pair_count", ID_W'(pair_count), ID_W'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    answer_t         nil;
    logic [2:0]      cmd;
    logic [ID_W-1:0] can;
    logic [ID_W-1:0] loc;
    int              issued;
    int              ep_len;
    int              mode;
    int              r;
    int              s;
    int              ls;
    bit              quiet;
    int              lim_bind, lim_can, lim_ob, lim_find, lim_fl, lim_fc, lim_unused;

    nil.status = ST_DONE;
    nil.id = '0;
    nil.count = '0;
    for (int i = 0; i < DEPTH; i++) pair_used[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = {$urandom, $urandom};
      if (id_pool[i] == '0) id_pool[i] = L1;
    end

    add_row(CMD_FIND_LOC, C1, '0, 1, ST_DONE,     '0, 0);
    add_row(CMD_CANON,    '0, L1, 1, ST_DONE,     L1, 0);
    add_row(CMD_BIND,     '0, L1, 1, ST_ZERO,     '0, 0);
    add_row(CMD_BIND,     C1, '0, 1, ST_ZERO,     '0, 0);
    add_row(CMD_BIND,     '0, '0, 1, ST_ZERO,     '0, 0);
    add_row(CMD_BIND,     C1, L1, 1, ST_DONE,     '0, 1);
    add_row(CMD_BIND,     C1, L1, 1, ST_DONE,     '0, 1);
    add_row(CMD_BIND,     C2, L1, 1, ST_CONFLICT, '0, 1);
    add_row(CMD_BIND,     C1, L2, 1, ST_CONFLICT, '0, 1);
    add_row(CMD_BIND,     C2, C2, 1, ST_DONE,     '0, 1);
    add_row(CMD_CANON,    '0, L1, 1, ST_DONE,     C1, 1);
    add_row(CMD_CANON_OB, '0, L1, 1, ST_DONE,     C1, 1);
    add_row(CMD_CANON_OB, '0, C1, 1, ST_DONE,     '0, 1);
    add_row(CMD_CANON_OB, '0, L2, 1, ST_DONE,     L2, 1);
    add_row(CMD_FIND_LOC, C1, '0, 1, ST_DONE,     L1, 1);
    add_row(CMD_FIND_LOC, '0, '0, 1, ST_DONE,     '0, 1);
    add_row(CMD_BIND,     C2, L2, 0, ST_DONE,     '0, 0);
    add_row(CMD_BIND,     C3, L3, 0, ST_DONE,     '0, 0);
    add_row(CMD_FORGET_L, '0, L1, 1, ST_DONE,     '0, 2);
    add_row(CMD_FORGET_L, '0, L1, 1, ST_DONE,     '0, 2);
    add_row(CMD_FORGET_C, C2, '0, 1, ST_DONE,     '0, 1);
    add_row(CMD_FORGET_C, '0, C1, 1, ST_DONE,     '0, 1);
    add_row(CMD_UNUSED,   C1, C1, 1, ST_DONE,     '0, 1);
    add_row(CMD_BIND,     C1, L1, 0, ST_DONE,     '0, 0);
    add_row(CMD_CLEAR,    C3, L3, 1, ST_DONE,     '0, 0);
    add_row(CMD_FIND_LOC, C3, '0, 1, ST_DONE,     '0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      issue_beat(script[i].cmd, script[i].can_id, script[i].loc_id, script[i].typed,
                 script[i].want, pick_gap(1'b0));

    // Episodes: 0 fills the table, 1 drains it, 2 mixes everything.
    issued = 0;
    while (issued < RANDOM_BEATS) begin
      ep_len = $urandom_range(40, 120);
      mode = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 2) == 0);
      if (issued == 0 || $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      case (mode)
        0: begin
          lim_bind = 70; lim_can = 78; lim_ob = 84; lim_find = 90;
          lim_fl = 94; lim_fc = 97; lim_unused = 99;
        end
        1: begin
          lim_bind = 15; lim_can = 30; lim_ob = 40; lim_find = 50;
          lim_fl = 72; lim_fc = 95; lim_unused = 97;
        end
        default: begin
          lim_bind = 30; lim_can = 45; lim_ob = 58; lim_find = 70;
          lim_fl = 80; lim_fc = 90; lim_unused = 97;
        end
      endcase
      for (int n = 0; n < ep_len && issued < RANDOM_BEATS; n++) begin
        r = $urandom_range(0, 99);
        if (r < lim_bind) cmd = CMD_BIND;
        else if (r < lim_can) cmd = CMD_CANON;
        else if (r < lim_ob) cmd = CMD_CANON_OB;
        else if (r < lim_find) cmd = CMD_FIND_LOC;
        else if (r < lim_fl) cmd = CMD_FORGET_L;
        else if (r < lim_fc) cmd = CMD_FORGET_C;
        else if (r < lim_unused) cmd = CMD_UNUSED;
        else cmd = CMD_CLEAR;
        can = {$urandom, $urandom};
        loc = {$urandom, $urandom};
        case (cmd)
          CMD_BIND: begin
            s = $urandom_range(0, 99);
            if (s < 20) begin
              loc = pick_key(1'b1);
              ls = slot_of_local(loc);
              can = (ls >= 0) ? pair_can[ls] : pick_key(1'b0);
            end else if (s < 25) begin
              loc = pick_key(1'b1);
              can = loc;
            end else if (s < 75) begin
              can = id_pool[$urandom_range(0, POOL_SIZE - 1)];
              loc = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
              can = pick_key(1'b0);
              loc = pick_key(1'b1);
            end
          end
          CMD_CANON, CMD_FORGET_L: loc = pick_key(1'b1);
          CMD_CANON_OB: loc = pick_key(1'($urandom_range(0, 1)));
          CMD_FIND_LOC, CMD_FORGET_C: can = pick_key(1'b0);
          default: ;
        endcase
        issue_beat(cmd, can, loc, 1'b0, nil, pick_gap(quiet));
        issued++;
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
